// ===== rtl/blfc_pkg.sv =====
// ----------------------------------------------------------------------------
// blfc_pkg
// Shared types and constants for the backlight level and fade controller.
// ----------------------------------------------------------------------------
package blfc_pkg;

  // Brightness limits and scaling.
  localparam int          LEVEL_MAX     = 255;
  localparam int          MAP_DEPTH_DEF = 256;
  localparam logic [6:0]  PCT_FULL      = 7'd100;
  // x / 100 == (x * 5243) >> 19 for every x below 2^15
  localparam logic [12:0] PCT_RECIP     = 13'd5243;
  localparam int          PCT_SHIFT     = 19;

  // Reset values of the state and configuration registers.
  localparam logic [7:0]  LEVEL_RST     = 8'd255;
  localparam logic [7:0]  FACTORY_RST   = 8'd15;

  // Input command codes.
  typedef enum logic [2:0] {
    CMD_SET_LEVEL = 3'd0,
    CMD_RAW_LEVEL = 3'd1,
    CMD_SET_FADE  = 3'd2,
    CMD_TICK      = 3'd3,
    CMD_MAP_WR    = 3'd4,
    CMD_STATUS    = 3'd5
  } cmd_t;

  // Result word kinds.
  typedef enum logic [1:0] {
    KIND_BRIGHT   = 2'd0,
    KIND_PWR_UP   = 2'd1,
    KIND_PWR_DOWN = 2'd2,
    KIND_STATUS   = 2'd3
  } kind_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAP_SIZE      = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_LEVEL = 2'd1;
  localparam logic [1:0] CFG_FACTORY_FORCE = 2'd2;
  localparam logic [1:0] CFG_FACTORY_LEVEL = 2'd3;

  typedef struct packed {
    logic [8:0] map_size;
    logic [7:0] default_level;
    logic       factory_force;
    logic [7:0] factory_level;
  } cfg_t;

  // Controller -> datapath commands (fade_set may come together with fade_now or div_start).
  typedef struct packed {
    logic load;       // capture input word
    logic raw;        // raw level write
    logic status;     // status-only result
    logic map_wr;     // level map write
    logic fade_set;   // new fade target, ramp stopped
    logic fade_now;   // zero duration: target applies at once
    logic div_start;  // start step period division
    logic div_step;   // one quotient bit
    logic tick_dec;   // ramp countdown
    logic tick_end;   // ramp reached target
    logic tick_step;  // one percent step
    logic resolve;    // set level: resolve, power state, map read
    logic mul;        // mapped level times percent
    logic scale;      // divide by 100
  } dp_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic [2:0] cmd;
    logic       dur_zero;
    logic       diff_zero;
    logic       ramp;
    logic       cnt_zero;
    logic       tgt_eq;
    logic       lvl_zero;
    logic       is_on;
    logic       res_zero;
    logic       pu;
    logic       div_last;
  } dp_stat_t;

endpackage

// ===== rtl/backlight_level_fade_controller.sv =====
// ----------------------------------------------------------------------------
// backlight_level_fade_controller
// Backlight level, power sequencing and percent fade control.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ----------------------------------
//  in_      input      in_valid/in_ready    cmd, level, percent, duration_ms,
//                                           map_index, map_value
//  out_     output     out_valid/out_ready  drive_kind, drive_value, light_on,
//                                           percent_now, last
//  cfg_     input      cfg_we               cfg_index, cfg_wdata
//
//  One input word at a time. After decode, a set level that reaches the
//  driver adds resolve, map read, multiply and scale; a fade with nonzero
//  duration runs the step period divider, one quotient bit per cycle.
//  Each result word waits for out_ready; up to two words per input.
//  Reset is synchronous, active low. The level map holds no reset value.
//  in_ready stays low while an input word is in work or its results wait.
//
module backlight_level_fade_controller import blfc_pkg::*; #(
  parameter int MAP_DEPTH = MAP_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input words
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_cmd,
  input  logic signed [8:0] in_level,
  input  logic [6:0]        in_percent,
  input  logic [15:0]       in_duration_ms,
  input  logic [7:0]        in_map_index,
  input  logic [7:0]        in_map_value,
  // result words
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_drive_kind,
  output logic [7:0]        out_drive_value,
  output logic              out_light_on,
  output logic [6:0]        out_percent_now,
  output logic              out_last,
  // configuration
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_wdata
);

  cfg_t     cfg_r;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  kind_t    main_kind;
  logic [7:0] main_val;
  logic     out_pu;

  // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.map_size      <= 9'd0;
      cfg_r.default_level <= LEVEL_RST;
      cfg_r.factory_force <= 1'b0;
      cfg_r.factory_level <= FACTORY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAP_SIZE:      cfg_r.map_size      <= cfg_wdata;
        CFG_DEFAULT_LEVEL: cfg_r.default_level <= cfg_wdata[7:0];
        CFG_FACTORY_FORCE: cfg_r.factory_force <= cfg_wdata[0];
        CFG_FACTORY_LEVEL: cfg_r.factory_level <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  blfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pu    (out_pu),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  blfc_dp #(
    .MAP_DEPTH (MAP_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cmd         (in_cmd),
    .in_level       (in_level),
    .in_percent     (in_percent),
    .in_duration_ms (in_duration_ms),
    .in_map_index   (in_map_index),
    .in_map_value   (in_map_value),
    .cfg            (cfg_r),
    .cmd            (dp_cmd),
    .stat           (dp_stat),
    .main_kind      (main_kind),
    .main_val       (main_val),
    .light_on       (out_light_on),
    .pct_now        (out_percent_now)
  );

  // A power-up word, when one is sent, precedes the main word of the same input.
  assign out_drive_kind  = out_pu ? KIND_PWR_UP : main_kind;
  assign out_drive_value = out_pu ? 8'd0 : main_val;
  assign out_last        = !out_pu;

`ifndef SYNTHESIS
  // input side and result side never open at once
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready && out_valid))
    else $error("input taken while results pending");

  // percent never leaves 0..100
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_percent_now <= PCT_FULL))
    else $error("percent_now above 100");

  // a taken power-up word is followed by the closing word of the same input
  a_pu_then_main: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_drive_kind == KIND_PWR_UP) |=>
      (out_valid && out_last && out_drive_kind != KIND_PWR_UP))
    else $error("power-up word not followed by main word");
`endif

endmodule

// ===== rtl/blfc_dp.sv =====
// ----------------------------------------------------------------------------
// blfc_dp
// Datapath: state registers, level map, percent scaler, step period divider.
// ----------------------------------------------------------------------------
module blfc_dp import blfc_pkg::*; #(
  parameter int MAP_DEPTH = MAP_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        in_cmd,
  input  logic signed [8:0] in_level,
  input  logic [6:0]        in_percent,
  input  logic [15:0]       in_duration_ms,
  input  logic [7:0]        in_map_index,
  input  logic [7:0]        in_map_value,
  input  cfg_t              cfg,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  output kind_t             main_kind,
  output logic [7:0]        main_val,
  output logic              light_on,
  output logic [6:0]        pct_now
);

  localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  // captured input word
  logic [2:0]        cmd_r;
  logic signed [8:0] lvl_r;
  logic [6:0]        pct_in_r;
  logic [15:0]       dur_r;
  logic [7:0]        midx_r;
  logic [7:0]        mval_r;

  // block state
  logic [7:0]  current_r;
  logic        is_on_r;
  logic [6:0]  tgt_r;
  logic [6:0]  pct_r;
  logic [15:0] period_r;
  logic [15:0] cnt_r;
  logic        ramp_r;

  // divider
  logic [6:0]  diff_r;
  logic [6:0]  rem_r;
  logic [15:0] quo_r;
  logic [3:0]  dcnt_r;

  // set level pipeline
  logic [7:0]  res_r;
  logic        hit_r;
  logic        pu_r;
  logic [7:0]  map_rd_r;
  logic [14:0] prod_r;
  kind_t       kind_r;
  logic [7:0]  val_r;

  logic [7:0]  map_mem [MAP_DEPTH];

  logic [6:0]        pct_sat;
  logic [6:0]        diff;
  logic signed [8:0] lvl_c;
  logic              lvl_zero;
  logic [7:0]        res_lvl;
  logic              hit;
  logic [6:0]        pct_step;
  logic [7:0]        raw_lvl;
  logic [7:0]        cal;
  logic [27:0]       scl;
  logic [7:0]        trial;
  logic              ge;
  logic [6:0]        rem_nxt;
  logic [15:0]       quo_nxt;

  always_comb begin
    pct_sat  = (pct_in_r > PCT_FULL) ? PCT_FULL : pct_in_r;
    diff     = (pct_sat > pct_r) ? (pct_sat - pct_r) : (pct_r - pct_sat);
    lvl_c    = (int'(lvl_r) > LEVEL_MAX) ? 9'(LEVEL_MAX) : lvl_r;
    lvl_zero = (lvl_c == 9'sd0);
    if (cfg.factory_force) begin
      res_lvl = cfg.factory_level;
    end else if (lvl_c[8]) begin
      res_lvl = cfg.default_level;
    end else begin
      res_lvl = lvl_c[7:0];
    end
    hit = (cfg.map_size != 9'd0) && ({1'b0, res_lvl} < cfg.map_size) &&
          (int'(res_lvl) < MAP_DEPTH);
    pct_step = (tgt_r > pct_r) ? (pct_r + 7'd1) : (pct_r - 7'd1);
    if (lvl_r[8]) begin
      raw_lvl = 8'd0;
    end else if (int'(lvl_r) > LEVEL_MAX) begin
      raw_lvl = 8'(LEVEL_MAX);
    end else begin
      raw_lvl = lvl_r[7:0];
    end
    cal     = hit_r ? map_rd_r : res_r;
    scl     = 28'(prod_r) * 28'(PCT_RECIP);
    // restoring division, one quotient bit per cycle
    trial   = {rem_r, quo_r[15]};
    ge      = (trial >= {1'b0, diff_r});
    rem_nxt = ge ? 7'(trial - {1'b0, diff_r}) : trial[6:0];
    quo_nxt = {quo_r[14:0], ge};
  end

  // level map
  always_ff @(posedge clk) begin
    if (cmd.map_wr && (int'(midx_r) < MAP_DEPTH)) begin
      map_mem[AW'(midx_r)] <= mval_r;
    end
    if (cmd.resolve) begin
      map_rd_r <= map_mem[AW'(res_lvl)];
    end
  end

  // payload and pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_cmd;
      lvl_r    <= in_level;
      pct_in_r <= in_percent;
      dur_r    <= in_duration_ms;
      midx_r   <= in_map_index;
      mval_r   <= in_map_value;
    end else if (cmd.fade_now || cmd.tick_step) begin
      lvl_r    <= $signed({1'b0, current_r});
    end
    if (cmd.div_start) begin
      diff_r <= diff;
      rem_r  <= 7'd0;
      quo_r  <= dur_r;
    end else if (cmd.div_step) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
    end
    if (cmd.resolve) begin
      res_r <= res_lvl;
      hit_r <= hit;
    end
    if (cmd.mul) begin
      prod_r <= 15'(cal) * 15'(pct_r);
    end
    if (cmd.raw) begin
      kind_r <= (raw_lvl != 8'd0) ? KIND_BRIGHT : KIND_PWR_DOWN;
      val_r  <= raw_lvl;
    end else if (cmd.status) begin
      kind_r <= KIND_STATUS;
      val_r  <= 8'd0;
    end else if (cmd.resolve) begin
      kind_r <= (lvl_zero || res_lvl == 8'd0) ? KIND_PWR_DOWN : KIND_BRIGHT;
      val_r  <= 8'd0;
    end else if (cmd.scale) begin
      val_r  <= scl[PCT_SHIFT +: 8];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_r <= LEVEL_RST;
      is_on_r   <= 1'b1;
      tgt_r     <= PCT_FULL;
      pct_r     <= PCT_FULL;
      period_r  <= 16'd0;
      cnt_r     <= 16'd0;
      ramp_r    <= 1'b0;
      dcnt_r    <= 4'd0;
      pu_r      <= 1'b0;
    end else begin
      if (cmd.load) begin
        pu_r <= 1'b0;
      end
      if (cmd.raw) begin
        current_r <= raw_lvl;
        if (raw_lvl == 8'd0) begin
          is_on_r <= 1'b0;
        end
      end
      if (cmd.fade_set) begin
        tgt_r    <= pct_sat;
        ramp_r   <= 1'b0;
        period_r <= 16'd0;
      end
      if (cmd.fade_now) begin
        pct_r <= pct_sat;
      end
      if (cmd.div_start) begin
        dcnt_r <= 4'd0;
      end
      if (cmd.div_step) begin
        dcnt_r <= dcnt_r + 4'd1;
        if (dcnt_r == '1) begin
          period_r <= quo_nxt;
          ramp_r   <= (quo_nxt != 16'd0);
          cnt_r    <= 16'd0;
        end
      end
      if (cmd.tick_dec) begin
        cnt_r <= cnt_r - 16'd1;
      end
      if (cmd.tick_end) begin
        ramp_r <= 1'b0;
      end
      if (cmd.tick_step) begin
        pct_r <= pct_step;
        if (tgt_r != pct_step && period_r != 16'd0) begin
          cnt_r <= period_r - 16'd1;
        end else begin
          ramp_r <= 1'b0;
        end
      end
      if (cmd.resolve) begin
        if (lvl_zero) begin
          if (is_on_r) begin
            current_r <= 8'd0;
            is_on_r   <= 1'b0;
          end
        end else begin
          pu_r      <= !is_on_r;
          current_r <= res_lvl;
          is_on_r   <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    stat.cmd       = cmd_r;
    stat.dur_zero  = (dur_r == 16'd0);
    stat.diff_zero = (diff == 7'd0);
    stat.ramp      = ramp_r;
    stat.cnt_zero  = (cnt_r == 16'd0);
    stat.tgt_eq    = (tgt_r == pct_r);
    stat.lvl_zero  = lvl_zero;
    stat.is_on     = is_on_r;
    stat.res_zero  = (res_lvl == 8'd0);
    stat.pu        = pu_r;
    stat.div_last  = (dcnt_r == '1);
  end

  assign main_kind = kind_r;
  assign main_val  = val_r;
  assign light_on  = is_on_r;
  assign pct_now   = pct_r;

endmodule

// ===== rtl/blfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// blfc_ctrl
// Controller: sequences one input word through the datapath and the results.
// ----------------------------------------------------------------------------
module blfc_ctrl import blfc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_pu,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DECODE   = 8'b0000_0010,
    ST_RESOLVE  = 8'b0000_0100,
    ST_MAP      = 8'b0000_1000,
    ST_SCALE    = 8'b0001_0000,
    ST_DIV      = 8'b0010_0000,
    ST_OUT_PU   = 8'b0100_0000,
    ST_OUT_MAIN = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_pu    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_IDLE;
        case (stat.cmd)
          CMD_SET_LEVEL: state_nxt = ST_RESOLVE;
          CMD_RAW_LEVEL: begin
            cmd.raw   = 1'b1;
            state_nxt = ST_OUT_MAIN;
          end
          CMD_SET_FADE: begin
            cmd.fade_set = 1'b1;
            if (stat.dur_zero) begin
              cmd.fade_now = 1'b1;
              state_nxt    = ST_RESOLVE;
            end else if (!stat.diff_zero) begin
              cmd.div_start = 1'b1;
              state_nxt     = ST_DIV;
            end
          end
          CMD_TICK: begin
            if (stat.ramp) begin
              if (!stat.cnt_zero) begin
                cmd.tick_dec = 1'b1;
              end else if (stat.tgt_eq) begin
                cmd.tick_end = 1'b1;
              end else begin
                cmd.tick_step = 1'b1;
                state_nxt     = ST_RESOLVE;
              end
            end
          end
          CMD_MAP_WR: cmd.map_wr = 1'b1;
          CMD_STATUS: begin
            cmd.status = 1'b1;
            state_nxt  = ST_OUT_MAIN;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_RESOLVE: begin
        cmd.resolve = 1'b1;
        if (stat.lvl_zero) begin
          state_nxt = stat.is_on ? ST_OUT_MAIN : ST_IDLE;
        end else if (stat.res_zero) begin
          state_nxt = stat.is_on ? ST_OUT_MAIN : ST_OUT_PU;
        end else begin
          state_nxt = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = stat.pu ? ST_OUT_PU : ST_OUT_MAIN;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT_PU: begin
        out_valid = 1'b1;
        out_pu    = 1'b1;
        if (out_ready) begin
          state_nxt = ST_OUT_MAIN;
        end
      end
      ST_OUT_MAIN: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
